// ===== src/hmac_pkg.sv =====
// ============================================================================
// hmac_pkg: shared types and constants for the HMAC-SHA256 engine
// Holds the SHA-256 round constants, initial value and the round-unit
// control and status structs.
// ============================================================================
package hmac_pkg;

  localparam int          BLOCK_BYTES = 64;
  localparam int unsigned WORD_W = 32;
  localparam logic [31:0] IPAD   = 32'h36363636;
  localparam logic [31:0] OPAD   = 32'h5c5c5c5c;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] OUTER_LEN = 32'd768;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;     // load chain into working vars, begin 64 rounds
  } cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;      // one-cycle pulse, chain updated
  } cmp_sts_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/hmac_sha256_engine_core.sv =====
// ============================================================================
// hmac_sha256_engine_core: HMAC-SHA256 over a byte stream
// A beat holds in_ready low until the engine has absorbed it; no new beat is
// taken before then. A beat that completes a block also waits for its
// compression, and the first beat of a message waits for the hash of key^ipad.
// A last beat runs one or two inner blocks and two outer blocks, then offers
// four MAC beats; in_ready returns after the fourth is taken. One round unit runs all.
// Synchronous active-low reset clears control state and key registers.
// ============================================================================
module hmac_sha256_engine_core import hmac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_mac_word,
  output logic [1:0]  out_word_index,
  output logic        out_mac_last
);

  localparam int FILL_W = $clog2(BLOCK_BYTES) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_IKEY, S_IKEY_W, S_ABS, S_PAD, S_PAD_W, S_LEN, S_LEN_W,
    S_OKEY, S_OKEY_W, S_OMSG, S_OMSG_W, S_OUT
  } state_t;

  state_t state_r;
  logic [63:0] key_r [8];
  word_t [7:0]  chain_r;
  word_t [7:0]  inner_r;
  word_t [15:0] blk_r;
  logic [FILL_W-1:0] fill_r;
  logic [63:0] bits_r;
  logic in_msg_r;
  logic [7:0] byte_r;
  logic bv_r, last_r;
  logic [1:0] oidx_r;

  cmp_ctl_t ctl;
  cmp_sts_t sts;
  word_t [15:0] cmp_blk;
  word_t [7:0]  cmp_out;

  hmac_round u_round (
    .clk, .rst_n, .ctl, .blk(cmp_blk), .chain_in(chain_r),
    .chain_out(cmp_out), .sts
  );

  // key pad block, chosen by phase
  function automatic word_t [15:0] key_blk(input logic [63:0] k [8], input word_t pad);
    word_t [15:0] b;
    for (int i = 0; i < 8; i++) begin
      b[2*i]   = k[i][63:32] ^ pad;
      b[2*i+1] = k[i][31:0] ^ pad;
    end
    return b;
  endfunction

  always_comb begin
    cmp_blk = blk_r;
    case (state_r)
      S_IKEY:  cmp_blk = key_blk(key_r, IPAD);
      S_OKEY:  cmp_blk = key_blk(key_r, OPAD);
      S_OMSG: begin
        for (int i = 0; i < 8; i++) cmp_blk[i] = inner_r[i];
        cmp_blk[8] = PAD_WORD;
        for (int i = 9; i < 15; i++) cmp_blk[i] = '0;
        cmp_blk[15] = OUTER_LEN;
      end
      default: cmp_blk = blk_r;
    endcase
  end

  assign ctl.start = (state_r == S_IKEY) || (state_r == S_ABS && fill_r == FILL_W'(BLOCK_BYTES))
                  || (state_r == S_PAD) || (state_r == S_LEN) || (state_r == S_OKEY)
                  || (state_r == S_OMSG);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_mac_word = {chain_r[{oidx_r, 1'b0}], chain_r[{oidx_r, 1'b1}]};
  assign out_word_index = oidx_r;
  assign out_mac_last = (oidx_r == 2'd3);

  // put a byte into the block at the fill position
  function automatic word_t [15:0] put(input word_t [15:0] b, input logic [FILL_W-1:0] f,
                                      input logic [7:0] v);
    word_t [15:0] r;
    r = b;
    r[f[5:2]][8*(3-f[1:0]) +: 8] = v;
    return r;
  endfunction

  // close the block: marker byte, zero tail, length words when they fit
  function automatic word_t [15:0] pad_blk(input word_t [15:0] b,
                                          input logic [FILL_W-1:0] f,
                                          input logic [63:0] len);
    word_t [15:0] r;
    r = put(b, f, 8'h80);
    for (int i = 0; i < 16; i++)
      if (4'(i) > f[5:2]) r[i] = '0;
    for (int j = 0; j < 4; j++)
      if (2'(j) > f[1:0]) r[f[5:2]][8*(3-j) +: 8] = '0;
    if (f < FILL_W'(BLOCK_BYTES - 8)) begin
      r[14] = len[63:32];
      r[15] = len[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_msg_r <= 1'b0;
      fill_r <= '0;
      bits_r <= '0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
    end else begin
      if (cfg_we) key_r[cfg_index] <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            byte_r <= in_data_byte;
            bv_r <= in_byte_valid;
            last_r <= in_last_item;
            if (!in_msg_r) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= iv_word(3'(i));
              fill_r <= '0;
              bits_r <= 64'(8 * BLOCK_BYTES);
              in_msg_r <= 1'b1;
              state_r <= S_IKEY;
            end else begin
              state_r <= S_ABS;
            end
          end
        end
        S_IKEY: state_r <= S_IKEY_W;
        S_IKEY_W: if (sts.done) begin
          chain_r <= cmp_out;
          state_r <= S_ABS;
        end
        S_ABS: begin
          // absorb byte, compress full block (fill hits block size), pad on last, else idle
          if (fill_r == FILL_W'(BLOCK_BYTES)) begin
            state_r <= S_IKEY_W;
            fill_r <= '0;
          end else if (bv_r) begin
            blk_r <= put(blk_r, fill_r, byte_r);
            fill_r <= fill_r + 1'b1;
            bits_r <= bits_r + 64'd8;
            bv_r <= 1'b0;
          end else if (last_r) begin
            blk_r <= pad_blk(blk_r, fill_r, bits_r);
            state_r <= (fill_r >= FILL_W'(BLOCK_BYTES - 8)) ? S_PAD : S_LEN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: state_r <= S_PAD_W;
        S_PAD_W: if (sts.done) begin
          chain_r <= cmp_out;
          // all-zero block with the bit length in words 14 (high) and 15 (low)
          blk_r <= {bits_r[31:0], bits_r[63:32], 448'd0};
          state_r <= S_LEN;
        end
        S_LEN: begin
          // start the final inner block, length words already in place
          state_r <= S_LEN_W;
        end
        S_LEN_W: if (sts.done) begin
          inner_r <= cmp_out;
          for (int i = 0; i < 8; i++) chain_r[i] <= iv_word(3'(i));
          state_r <= S_OKEY;
        end
        S_OKEY: state_r <= S_OKEY_W;
        S_OKEY_W: if (sts.done) begin
          chain_r <= cmp_out;
          state_r <= S_OMSG;
        end
        S_OMSG: state_r <= S_OMSG_W;
        S_OMSG_W: if (sts.done) begin
          chain_r <= cmp_out;
          oidx_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          oidx_r <= oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            in_msg_r <= 1'b0;
            fill_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/hmac_round.sv =====
// ============================================================================
// hmac_round: iterative SHA-256 compression unit
// One round per cycle over a 16-word rolling schedule; adds the working
// variables back into the chain after round 63.
// ============================================================================
module hmac_round import hmac_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  cmp_ctl_t       ctl,
  input  word_t [15:0]   blk,
  input  word_t [7:0]    chain_in,
  output word_t [7:0]    chain_out,
  output cmp_sts_t       sts
);

  word_t [15:0] w_r;
  word_t [7:0]  v_r;
  word_t [7:0]  base_r;
  logic [5:0]   rnd_r;
  logic         busy_r;
  logic         done_r;

  word_t s0, s1, w_new, t1, t2, e, a;

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + round_k(rnd_r) + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        w_r    <= blk;
        v_r    <= chain_in;
        base_r <= chain_in;
      end else if (busy_r) begin
        // advance schedule window and working variables
        w_r <= {w_new, w_r[15:1]};
        v_r <= {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = base_r[i] + v_r[i];
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== bench/mac_checker.sv =====
// ----------------------------------------------------------------------------
// mac_checker: HMAC-SHA256 scoreboard
// Watches the byte and MAC channels and the key write port, keeps its own
// HMAC-SHA256 state, queues the four MAC words due on each final beat and
// compares every MAC beat against the oldest queued word.
// ----------------------------------------------------------------------------
module mac_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_mac_word,
  input  logic [1:0]  out_word_index,
  input  logic        out_mac_last,
  output int          fail_count,
  output int          pending_words,
  output int          mac_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } mac_beat_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [63:0] key_q [8];
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [31:0] inner [8];
  int unsigned fill;
  logic [63:0] bit_len;
  logic        open_msg;
  mac_beat_t   mac_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress(inout logic [31:0] st [8], input logic [31:0] b [16]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = b[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = st;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) st[i] = st[i] + v[i];
  endtask

  task automatic hash_key_block(input logic [31:0] pad);
    logic [31:0] kb [16];
    for (int i = 0; i < 8; i++) begin
      kb[2*i]   = key_q[i][63:32] ^ pad;
      kb[2*i+1] = key_q[i][31:0] ^ pad;
    end
    chain = H_INIT;
    sha_compress(chain, kb);
  endtask

  task automatic push_byte(input logic [7:0] b);
    if (fill[1:0] == 0) blk[fill >> 2] = '0;
    blk[fill >> 2][24 - 8 * fill[1:0] +: 8] = b;
    fill++;
  endtask

  task automatic take_beat(input logic [7:0] b, input logic bv, input logic lst);
    logic [31:0] ob [16];
    if (!open_msg) begin
      hash_key_block(32'h36363636);
      fill = 0;
      bit_len = 64'd512;
      open_msg = 1'b1;
    end
    if (bv) begin
      push_byte(b);
      bit_len += 64'd8;
      if (fill >= 64) begin
        sha_compress(chain, blk);
        fill = 0;
      end
    end
    if (!lst) return;
    // close the inner hash: marker, word align, length (maybe an extra block)
    push_byte(8'h80);
    while (fill[1:0] != 0) push_byte(8'h00);
    if (fill > 56) begin
      for (int i = fill >> 2; i < 16; i++) blk[i] = '0;
      sha_compress(chain, blk);
      fill = 0;
    end
    for (int i = fill >> 2; i < 14; i++) blk[i] = '0;
    blk[14] = bit_len[63:32];
    blk[15] = bit_len[31:0];
    sha_compress(chain, blk);
    inner = chain;
    hash_key_block(32'h5c5c5c5c);
    for (int i = 0; i < 8; i++) ob[i] = inner[i];
    ob[8] = 32'h80000000;
    for (int i = 9; i < 15; i++) ob[i] = '0;
    ob[15] = 32'd768;
    sha_compress(chain, ob);
    for (int k = 0; k < 4; k++)
      mac_q.push_back('{word: {chain[2*k], chain[2*k+1]}, idx: 2'(k), last: (k == 3)});
    fill = 0;
    open_msg = 1'b0;
  endtask

  always @(posedge clk) begin
    mac_beat_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_q[i] = '0;
      fill = 0;
      bit_len = '0;
      open_msg = 1'b0;
      mac_q.delete();
      fail_count = 0;
      mac_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        mac_count++;
        if (mac_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected MAC beat word=%h idx=%0d last=%0b", $realtime,
                   out_mac_word, out_word_index, out_mac_last);
        end else begin
          exp_b = mac_q.pop_front();
          if (exp_b.word !== out_mac_word || exp_b.idx !== out_word_index ||
              exp_b.last !== out_mac_last) begin
            fail_count++;
            $display("%0t: MAC mismatch expected word=%h idx=%0d last=%0b got word=%h idx=%0d last=%0b",
                     $realtime, exp_b.word, exp_b.idx, exp_b.last,
                     out_mac_word, out_word_index, out_mac_last);
          end
        end
      end
      if (in_valid && in_ready) take_beat(in_data_byte, in_byte_valid, in_last_item);
      // key write takes effect after any beat in this same edge
      if (cfg_we) key_q[cfg_index] = cfg_wdata;
    end
    pending_words = mac_q.size();
  end
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: HMAC-SHA256 engine testbench
// Writes keys, streams messages of varied length and shape through the byte
// channel with random idling on both sides, and lets mac_checker verify
// every MAC word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_WORDS = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_mac_word;
  logic [1:0]  out_word_index;
  logic        out_mac_last;

  int  fail_count, pending_words, mac_count;
  int  beats_sent = 0;
  int  msgs_sent = 0;
  bit  quiet = 1'b0;   // no idling on either side in the closing stretch

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hmac_sha256_engine_core DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_data_byte, .in_byte_valid, .in_last_item,
    .out_valid, .out_ready, .out_mac_word, .out_word_index, .out_mac_last
  );

  mac_checker u_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_data_byte, .in_byte_valid, .in_last_item,
    .out_valid, .out_ready, .out_mac_word, .out_word_index, .out_mac_last,
    .fail_count, .pending_words, .mac_count
  );

  // Receiver: mostly ready, with stall bursts of random length.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one beat and hold it until it is accepted; maybe idle first.
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_byte_valid <= bv;
    in_last_item  <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (lst) msgs_sent++;
  endtask

  // Drop valid and wait until every MAC word has drained and the engine is
  // idle again, so a key write lands on an idle block.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] k [KEY_WORDS]);
    for (int i = 0; i < KEY_WORDS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= k[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One message of len bytes with random content; an empty final beat if asked or if len is 0.
  task automatic send_message(input int len, input bit empty_tail);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, !empty_tail && (i == len - 1));
    if (empty_tail || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    logic [63:0] key [KEY_WORDS];
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero key, empty message then one-byte extremes.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    drain();
    // All-ones key; idle beat opens the message, then bytes and idle beats, empty final.
    for (int i = 0; i < KEY_WORDS; i++) key[i] = '1;
    write_key(key);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'ha5, 1'b1, 1'b0);
    send_beat(8'h3c, 1'b0, 1'b0);
    send_beat(8'hc3, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    drain();
    // Short key; hold the sender until the engine is idle again (drain),
    // then change the key mid-message so the outer pad sees the new one.
    key[0] = 64'h6b65790000000000;
    for (int i = 1; i < KEY_WORDS; i++) key[i] = '0;
    write_key(key);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    drain();
    key[7] = 64'h0123456789abcdef;
    write_key(key);
    send_beat(8'h7f, 1'b1, 1'b1);
    drain();

    // Random: mostly short messages, a few across block boundaries.
    while (beats_sent < 160) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < KEY_WORDS; i++)
          key[i] = $urandom_range(0, 3) == 0 ? 64'h0 : {$urandom, $urandom};
        write_key(key);
      end
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(54, 66);   // around a block boundary; 56 to 63 spill padding
        1:       len = 0;
        default: len = $urandom_range(1, 12);
      endcase
      // keep the total close to the planned beat count
      if (beats_sent + len > 168) len = 168 - beats_sent;
      if (beats_sent > 130) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 3) == 0);
      drain();
    end

    $display("Covered %0d beats in %0d messages, %0d MAC words checked,",
             beats_sent, msgs_sent, mac_count);
    $display("with empty/idle beats, block-spanning lengths and key changes.");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
src/hmac_pkg.sv
src/hmac_round.sv
src/hmac_sha256_engine_core.sv
bench/mac_checker.sv
bench/tb_top.sv
